@@ rtl/mhpq_pkg.sv @@
`default_nettype none

package mhpq_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_PEEK   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] key_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] result_key;
      logic [6:0]         found_slot;
      logic [7:0]         entry_total;
   } rsp_type;

   // memory read address source
   typedef enum logic [2:0] {
      RA_ROOT   = 3'd0,
      RA_LAST   = 3'd1,
      RA_PARENT = 3'd2,
      RA_LEFT   = 3'd3,
      RA_RIGHT  = 3'd4,
      RA_SCAN   = 3'd5
   } rd_sel_type;

   // memory write data source
   typedef enum logic [1:0] {
      WD_KEY  = 2'd0,
      WD_RD   = 2'd1,
      WD_BEST = 2'd2
   } wr_sel_type;

   typedef enum logic [2:0] {
      POS_HOLD   = 3'd0,
      POS_COUNT  = 3'd1,
      POS_ROOT   = 3'd2,
      POS_PARENT = 3'd3,
      POS_BEST   = 3'd4
   } pos_op_type;

   typedef struct packed {
      logic       start;
      logic       set_status;
      status_type status_val;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      pos_op_type pos_op;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cap_result;
      logic       cap_last;
      logic       cap_left;
      logic       cap_right;
      logic       scan_start;
      logic       scan_step;
      logic       cap_slot;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic count_one;
      logic at_root;
      logic parent_greater;
      logic left_out;
      logic right_in;
      logic best_less;
      logic scan_hit;
      logic scan_done;
      logic scan_more;
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/min_heap_priority_queue_unit.sv @@
// Insert climbs one level per step while the parent is greater; full gets ST_FULL.
// Delete-min moves the last entry to the root and descends while a child is smaller;
// a single entry needs no descent. Peek reads the root; an empty heap gets ST_EMPTY.
// Search compares held entries in slot order until one matches; one read port.
// One request in flight; the next is taken while the result word waits.
// Synchronous reset empties the heap; the key memory is not cleared.
`default_nettype none

module min_heap_priority_queue_unit
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.operation),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mhpq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/mhpq_datapath.sv @@
`default_nettype none

module mhpq_datapath
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output stat_type     stat,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;

   logic signed [31:0] heap_mem [CAPACITY];
   logic signed [31:0] rd_data_ff;

   logic [CW-1:0]      count_ff, count_in;
   logic signed [31:0] key_ff, key_in;
   status_type         status_ff, status_in;
   logic signed [31:0] result_ff, result_in;
   logic [AW-1:0]      slot_ff, slot_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic signed [31:0] best_key_ff, best_key_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      cmp_idx_ff, cmp_idx_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CW-1:0]      count_m1;
   logic [AW-1:0]      parent;
   logic [IW-1:0]      left_idx, right_idx, count_ext;
   logic [AW-1:0]      rd_addr;
   logic signed [31:0] wr_data;
   logic [CW+7:0]      total_wide;
   logic [AW+6:0]      slot_wide;

   assign count_m1  = count_ff - CW'(1);
   assign parent    = (pos_ff - AW'(1)) >> 1;
   assign left_idx  = {1'b0, pos_ff, 1'b1};
   assign right_idx = left_idx + IW'(1);
   assign count_ext = IW'(count_ff);

   always_comb begin
      case (cmd.rd_sel)
         RA_ROOT:   rd_addr = '0;
         RA_LAST:   rd_addr = count_m1[AW-1:0];
         RA_PARENT: rd_addr = parent;
         RA_LEFT:   rd_addr = left_idx[AW-1:0];
         RA_RIGHT:  rd_addr = right_idx[AW-1:0];
         RA_SCAN:   rd_addr = scan_idx_ff[AW-1:0];
         default:   rd_addr = '0;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WD_KEY:  wr_data = key_ff;
         WD_RD:   wr_data = rd_data_ff;
         WD_BEST: wr_data = best_key_ff;
         default: wr_data = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         heap_mem[pos_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= heap_mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_m1;
      end

      key_in = key_ff;
      if (cmd.start) begin
         key_in = req_data.key_value;
      end else if (cmd.cap_last) begin
         key_in = rd_data_ff;
      end

      status_in = status_ff;
      if (cmd.start) begin
         status_in = ST_OK;
      end
      if (cmd.set_status) begin
         status_in = cmd.status_val;
      end

      result_in = result_ff;
      if (cmd.start) begin
         result_in = '0;
      end else if (cmd.cap_result) begin
         result_in = rd_data_ff;
      end

      slot_in = slot_ff;
      if (cmd.start) begin
         slot_in = '0;
      end else if (cmd.cap_slot) begin
         slot_in = cmp_idx_ff;
      end

      case (cmd.pos_op)
         POS_COUNT:  pos_in = count_ff[AW-1:0];
         POS_ROOT:   pos_in = '0;
         POS_PARENT: pos_in = parent;
         POS_BEST:   pos_in = best_idx_ff;
         default:    pos_in = pos_ff;
      endcase

      best_key_in = best_key_ff;
      best_idx_in = best_idx_ff;
      if (cmd.cap_left) begin
         best_key_in = rd_data_ff;
         best_idx_in = left_idx[AW-1:0];
      end else if (cmd.cap_right && (rd_data_ff < best_key_ff)) begin
         // left child wins a tie
         best_key_in = rd_data_ff;
         best_idx_in = right_idx[AW-1:0];
      end

      scan_idx_in = scan_idx_ff;
      cmp_idx_in  = cmp_idx_ff;
      pend_in     = 1'b0;
      if (cmd.scan_start) begin
         scan_idx_in = '0;
      end else if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + CW'(1);
         cmp_idx_in  = scan_idx_ff[AW-1:0];
         pend_in     = 1'b1;
      end

      total_wide = {8'd0, count_ff};
      slot_wide  = {7'd0, slot_ff};
      rsp_in     = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.status      = status_ff;
         rsp_in.result_key  = result_ff;
         rsp_in.found_slot  = slot_wide[6:0];
         rsp_in.entry_total = total_wide[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      key_ff      <= key_in;
      status_ff   <= status_in;
      result_ff   <= result_in;
      slot_ff     <= slot_in;
      pos_ff      <= pos_in;
      best_key_ff <= best_key_in;
      best_idx_ff <= best_idx_in;
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      stat.empty          = (count_ff == '0);
      stat.full           = (count_ff == CW'(CAPACITY));
      stat.count_one      = (count_ff == CW'(1));
      stat.at_root        = (pos_ff == '0);
      stat.parent_greater = (rd_data_ff > key_ff);
      stat.left_out       = (left_idx >= count_ext);
      stat.right_in       = (right_idx < count_ext);
      stat.best_less      = (best_key_ff < key_ff);
      stat.scan_hit       = pend_ff && (rd_data_ff == key_ff);
      stat.scan_done      = !pend_ff && (scan_idx_ff >= count_ff);
      stat.scan_more      = (scan_idx_ff < count_ff);
   end

   assign rsp_data = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (IW'(pos_ff) < count_ext))
      else $error("write outside the held entries");

   a_read_in_heap: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (IW'(rd_addr) < count_ext))
      else $error("read outside the held entries");

   a_scan_in_heap: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (CW'(cmp_idx_ff) < count_ff))
      else $error("search compare past the last entry");
`endif

endmodule

`default_nettype wire

@@ rtl/mhpq_ctrl.sv @@
`default_nettype none

module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire op_type   req_op,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_INS_RD   = 12'b0000_0000_0010,
      S_INS_CMP  = 12'b0000_0000_0100,
      S_DEL_ROOT = 12'b0000_0000_1000,
      S_DEL_LAST = 12'b0000_0001_0000,
      S_DN_L     = 12'b0000_0010_0000,
      S_DN_R     = 12'b0000_0100_0000,
      S_DN_RC    = 12'b0000_1000_0000,
      S_DN_CMP   = 12'b0001_0000_0000,
      S_PEEK_RD  = 12'b0010_0000_0000,
      S_SRCH     = 12'b0100_0000_0000,
      S_FINISH   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.status_val = ST_OK;
      cmd.rd_sel     = RA_ROOT;
      cmd.wr_sel     = WD_KEY;
      cmd.pos_op     = POS_HOLD;
      state_in       = state_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               unique case (req_op) inside
                  OP_INSERT: begin
                     if (stat.full) begin
                        cmd.set_status = 1'b1;
                        cmd.status_val = ST_FULL;
                        state_in       = S_FINISH;
                     end else begin
                        cmd.cnt_inc = 1'b1;
                        cmd.pos_op  = POS_COUNT;
                        state_in    = S_INS_RD;
                     end
                  end
                  OP_DELETE, OP_PEEK: begin
                     if (stat.empty) begin
                        cmd.set_status = 1'b1;
                        cmd.status_val = ST_EMPTY;
                        state_in       = S_FINISH;
                     end else begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_sel = RA_ROOT;
                        state_in   = (req_op == OP_DELETE) ? S_DEL_ROOT : S_PEEK_RD;
                     end
                  end
                  OP_SEARCH: begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SRCH;
                  end
               endcase
            end
         end
         // hole moves up: parent drops into the hole while it is greater
         S_INS_RD: begin
            if (stat.at_root) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WD_KEY;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_PARENT;
               state_in   = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.parent_greater) begin
               cmd.wr_sel = WD_RD;
               cmd.pos_op = POS_PARENT;
               state_in   = S_INS_RD;
            end else begin
               cmd.wr_sel = WD_KEY;
               state_in   = S_FINISH;
            end
         end
         S_DEL_ROOT: begin
            cmd.cap_result = 1'b1;
            cmd.cnt_dec    = 1'b1;
            if (stat.count_one) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_LAST;
               state_in   = S_DEL_LAST;
            end
         end
         S_DEL_LAST: begin
            cmd.cap_last = 1'b1;
            cmd.pos_op   = POS_ROOT;
            state_in     = S_DN_L;
         end
         // hole moves down: smaller child rises while below the moved key
         S_DN_L: begin
            if (stat.left_out) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WD_KEY;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_LEFT;
               state_in   = S_DN_R;
            end
         end
         S_DN_R: begin
            cmd.cap_left = 1'b1;
            if (stat.right_in) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_RIGHT;
               state_in   = S_DN_RC;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_RC: begin
            cmd.cap_right = 1'b1;
            state_in      = S_DN_CMP;
         end
         S_DN_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.best_less) begin
               cmd.wr_sel = WD_BEST;
               cmd.pos_op = POS_BEST;
               state_in   = S_DN_L;
            end else begin
               cmd.wr_sel = WD_KEY;
               state_in   = S_FINISH;
            end
         end
         S_PEEK_RD: begin
            cmd.cap_result = 1'b1;
            state_in       = S_FINISH;
         end
         // one read issued per cycle, compared the cycle after
         S_SRCH: begin
            if (stat.scan_hit) begin
               cmd.cap_slot = 1'b1;
               state_in     = S_FINISH;
            end else if (stat.scan_done) begin
               cmd.set_status = 1'b1;
               cmd.status_val = ST_NOT_FOUND;
               state_in       = S_FINISH;
            end else if (stat.scan_more) begin
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = RA_SCAN;
               cmd.scan_step = 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken without leaving idle");

   a_load_from_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("result load did not raise valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.load_rsp)
      else $error("pending result word overwritten");
`endif

endmodule

`default_nettype wire

@@ tb/min_heap_priority_queue_unit_test.sv @@
`default_nettype none

module min_heap_priority_queue_unit_test;
   import mhpq_pkg::*;

   localparam int CAPACITY = 128;
   localparam int ITEM_TARGET = 1250;
   localparam int QUIET_TAIL = 150;     // last words are sent with no idling
   localparam int SETTLE_CYCLES = 150;  // longest search plus margin
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DIRECTED_ROWS = 24;

   typedef enum {GROW, SHRINK, FILL, DRAIN} phase_kind_type;

   typedef struct packed {
      req_type word;
      logic    typed;
      rsp_type want;
   } directed_row_type;

   // ops on an empty heap, the key extremes, ties between children
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{OP_PEEK,   32'sd0},          1'b1, '{ST_EMPTY, 32'sd0, 7'd0, 8'd0}},
      '{'{OP_DELETE, 32'sd0},          1'b1, '{ST_EMPTY, 32'sd0, 7'd0, 8'd0}},
      '{'{OP_SEARCH, 32'sd0},          1'b1, '{ST_NOT_FOUND, 32'sd0, 7'd0, 8'd0}},
      '{'{OP_INSERT, 32'sh7FFFFFFF},   1'b1, '{ST_OK, 32'sd0, 7'd0, 8'd1}},
      '{'{OP_INSERT, 32'sh80000000},   1'b1, '{ST_OK, 32'sd0, 7'd0, 8'd2}},
      '{'{OP_PEEK,   32'sh12345678},   1'b1, '{ST_OK, 32'sh80000000, 7'd0, 8'd2}},
      '{'{OP_SEARCH, 32'sh7FFFFFFF},   1'b0, '0},
      '{'{OP_SEARCH, 32'sh80000000},   1'b1, '{ST_OK, 32'sd0, 7'd0, 8'd2}},
      '{'{OP_SEARCH, 32'sd5},          1'b1, '{ST_NOT_FOUND, 32'sd0, 7'd0, 8'd2}},
      '{'{OP_DELETE, 32'shFFFFFFFF},   1'b1, '{ST_OK, 32'sh80000000, 7'd0, 8'd1}},
      '{'{OP_DELETE, 32'sd0},          1'b1, '{ST_OK, 32'sh7FFFFFFF, 7'd0, 8'd0}},
      '{'{OP_DELETE, 32'sd0},          1'b1, '{ST_EMPTY, 32'sd0, 7'd0, 8'd0}},
      '{'{OP_INSERT, 32'sd5},          1'b0, '0},
      '{'{OP_INSERT, 32'sd5},          1'b0, '0},
      '{'{OP_INSERT, 32'sd5},          1'b0, '0},
      '{'{OP_INSERT, 32'shFFFFFFFF},   1'b0, '0},
      '{'{OP_INSERT, 32'sd0},          1'b0, '0},
      '{'{OP_DELETE, 32'sd0},          1'b0, '0},
      '{'{OP_DELETE, 32'sd0},          1'b0, '0},
      '{'{OP_SEARCH, 32'sd5},          1'b0, '0},
      '{'{OP_INSERT, 32'shFFFFFFFF},   1'b0, '0},
      '{'{OP_PEEK,   32'sd0},          1'b0, '0},
      '{'{OP_SEARCH, 32'shFFFFFFFF},   1'b0, '0},
      '{'{OP_INSERT, 32'sd0},          1'b0, '0}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic signed [31:0] heap_keys [CAPACITY];
   int                 heap_size = 0;
   rsp_type            pending_results [$];
   int                 error_count = 0;
   int                 words_sent = 0;
   int                 cycle_count = 0;
   int                 status_seen [4] = '{0, 0, 0, 0};
   bit                 idle_on = 1'b1;

   min_heap_priority_queue_unit #(
      .CAPACITY(CAPACITY)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // heap update and result for one accepted request word
   function automatic rsp_type predict_request(req_type w);
      rsp_type            r;
      int                 pos;
      int                 parent;
      int                 best;
      int                 lc;
      logic signed [31:0] tmp;
      r = '0;
      r.status = ST_OK;
      case (w.operation)
         OP_INSERT: begin
            if (heap_size >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               heap_keys[heap_size] = w.key_value;
               pos = heap_size;
               heap_size++;
               while (pos > 0) begin
                  parent = (pos - 1) / 2;
                  if (heap_keys[parent] <= heap_keys[pos]) break;
                  tmp = heap_keys[parent];
                  heap_keys[parent] = heap_keys[pos];
                  heap_keys[pos] = tmp;
                  pos = parent;
               end
            end
         end
         OP_DELETE: begin
            if (heap_size == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.result_key = heap_keys[0];
               heap_size--;
               heap_keys[0] = heap_keys[heap_size];
               pos = 0;
               forever begin
                  best = pos;
                  lc = 2 * pos + 1;
                  // strict compares: left child wins a tie
                  if (lc < heap_size && heap_keys[lc] < heap_keys[best]) best = lc;
                  if (lc + 1 < heap_size && heap_keys[lc + 1] < heap_keys[best])
                     best = lc + 1;
                  if (best == pos) break;
                  tmp = heap_keys[best];
                  heap_keys[best] = heap_keys[pos];
                  heap_keys[pos] = tmp;
                  pos = best;
               end
            end
         end
         OP_PEEK: begin
            if (heap_size == 0) r.status = ST_EMPTY;
            else r.result_key = heap_keys[0];
         end
         default: begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < heap_size; i++) begin
               if (heap_keys[i] == w.key_value) begin
                  r.status = ST_OK;
                  r.found_slot = 7'(i);
                  break;
               end
            end
         end
      endcase
      r.entry_total = 8'(heap_size);
      return r;
   endfunction

   // small keys on four draws in ten, so duplicates and ties are common
   function automatic logic signed [31:0] random_key();
      logic signed [31:0] k;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: k = 32'sh7FFFFFFF;
               1: k = 32'sh80000000;
               2: k = 32'sd0;
               default: k = -32'sd1;
            endcase
         end
         1, 2, 3, 4: k = int'($urandom_range(0, 16)) - 8;
         default: k = $urandom;
      endcase
      return k;
   endfunction

   function automatic req_type next_word(int insert_pct, int delete_pct);
      req_type w;
      int      roll;
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) w.operation = OP_INSERT;
      else if (roll < insert_pct + delete_pct) w.operation = OP_DELETE;
      else if ($urandom_range(0, 1)) w.operation = OP_PEEK;
      else w.operation = OP_SEARCH;
      w.key_value = random_key();
      // half the searches on a non-empty heap look for a key that is held
      if (w.operation == OP_SEARCH && heap_size > 0 && $urandom_range(0, 1))
         w.key_value = heap_keys[$urandom_range(0, heap_size - 1)];
      return w;
   endfunction

   task automatic push_request(input req_type w, input logic typed, input rsp_type want);
      rsp_type predicted;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_data <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_request(w);
      pending_results.push_back(typed ? want : predicted);
      words_sent++;
      idle_on = (words_sent < ITEM_TARGET - QUIET_TAIL);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         status_seen[int'(rsp_data.status)]++;
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.result_key !== want.result_key) begin
               $error("result_key: expected %0d, got %0d", want.result_key,
                      rsp_data.result_key);
               error_count++;
            end
            if (rsp_data.found_slot !== want.found_slot) begin
               $error("found_slot: expected %0d, got %0d", want.found_slot,
                      rsp_data.found_slot);
               error_count++;
            end
            if (rsp_data.entry_total !== want.entry_total) begin
               $error("entry_total: expected %0d, got %0d", want.entry_total,
                      rsp_data.entry_total);
               error_count++;
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   initial begin
      phase_kind_type phase_kind;
      int             phase_index;
      int             full_phases;
      phase_index = 0;
      full_phases = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         push_request(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

      while (words_sent < ITEM_TARGET) begin
         if (phase_index % 5 == 1) phase_kind = FILL;
         else phase_kind = phase_kind_type'($urandom_range(0, 3));
         case (phase_kind)
            GROW: repeat ($urandom_range(30, 90)) push_request(next_word(55, 15), 1'b0, '0);
            SHRINK: repeat ($urandom_range(30, 90)) push_request(next_word(10, 60), 1'b0, '0);
            FILL: begin
               while (heap_size < CAPACITY) push_request(next_word(85, 5), 1'b0, '0);
               full_phases++;
               repeat ($urandom_range(1, 4)) push_request(next_word(100, 0), 1'b0, '0);
               repeat ($urandom_range(3, 10)) push_request(next_word(40, 20), 1'b0, '0);
            end
            default: begin
               while (heap_size > 0) push_request(next_word(5, 80), 1'b0, '0);
               repeat ($urandom_range(2, 6)) push_request(next_word(10, 30), 1'b0, '0);
            end
         endcase
         phase_index++;
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d request words over %0d phases, heap filled to capacity %0d times.",
               words_sent, phase_index, full_phases);
      $display("Result words by status: ok %0d, full %0d, empty %0d, not found %0d.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
